// ===== hdl/olst_pkg.sv =====
// ----------------------------------------------------------------------------
// olst_pkg: shared types and codes for the ordered list store
// Request and status codes, field widths and the result record that the
// sequencer hands to the output stage.
// ----------------------------------------------------------------------------
package olst_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int FOUND_W = 6;
  localparam int COUNT_W = 7;

  // request codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] read_value;
    logic [FOUND_W-1:0] found_position;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
  } res_t;

endpackage

// ===== hdl/olst_mem.sv =====
// ----------------------------------------------------------------------------
// olst_mem: entry store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module olst_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [olst_pkg::VALUE_W-1:0]  wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [olst_pkg::VALUE_W-1:0]  rd_data
);

  logic [olst_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/olst_ctrl.sv =====
// ----------------------------------------------------------------------------
// olst_ctrl: request sequencer
// Decodes a request, then walks the store one entry per cycle through a
// shared pointer / pending-read tag: downward for the insert shift,
// upward for the find scan, where an equality compare checks each entry.
// ----------------------------------------------------------------------------
module olst_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_op,
  input  logic [olst_pkg::VALUE_W-1:0]    in_value,
  input  logic [olst_pkg::POS_W-1:0]      in_position,
  input  logic                            out_free,
  output logic                            res_valid,
  output olst_pkg::res_t                  res,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output logic [olst_pkg::VALUE_W-1:0]    wr_data,
  output logic [AW-1:0]                   rd_addr,
  input  logic [olst_pkg::VALUE_W-1:0]    rd_data
);

  localparam int XW = (CW > olst_pkg::POS_W) ? CW : olst_pkg::POS_W;
  localparam int FW = (AW > olst_pkg::FOUND_W) ? AW : olst_pkg::FOUND_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SHIFT, S_PUT, S_RDWAIT, S_SCAN, S_DONE
  } state_t;

  state_t                          state;
  logic [1:0]                      op;
  logic [olst_pkg::VALUE_W-1:0]    word;
  logic [olst_pkg::POS_W-1:0]      pos;
  logic [CW-1:0]                   count;
  logic [AW-1:0]                   ptr;
  logic [AW-1:0]                   tag;
  logic [CW-1:0]                   rem;
  logic                            pend;
  logic [1:0]                      status;
  logic [olst_pkg::VALUE_W-1:0]    rd_val;
  logic [AW-1:0]                   found;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [FW-1:0] found_x;
  logic [AW-1:0] pos_idx;
  logic          full;
  logic          issue;
  logic          match;

  assign pos_x   = XW'(pos);
  assign cnt_x   = XW'(count);
  assign found_x = FW'(found);
  assign pos_idx = pos_x[AW-1:0];
  assign full    = (count == CW'(CAPACITY));
  // a read goes out while entries remain to be walked
  assign issue   = ((state == S_SHIFT) || (state == S_SCAN)) && (rem != '0);
  assign match   = pend && (rd_data == word);

  assign rd_addr   = (state == S_DECODE) ? pos_idx : ptr;
  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE) && out_free;

  assign res.status         = status;
  assign res.read_value     = rd_val;
  assign res.found_position = found_x[olst_pkg::FOUND_W-1:0];
  assign res.count          = cnt_x[olst_pkg::COUNT_W-1:0];
  assign res.empty_res      = (count == '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = word;
    unique case (state)
      S_DECODE: begin
        if (op == olst_pkg::OP_APPEND && !full) begin
          wr_en   = 1'b1;
          wr_addr = count[AW-1:0];
        end
      end
      S_SHIFT: begin
        // entry read last cycle moves up by one
        wr_en   = pend;
        wr_addr = AW'(tag + 1'b1);
        wr_data = rd_data;
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= in_op;
            word  <= in_value;
            pos   <= in_position;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          status <= olst_pkg::ST_OK;
          rd_val <= '0;
          found  <= '0;
          pend   <= 1'b0;
          unique case (op)
            olst_pkg::OP_APPEND: begin
              if (full) begin
                status <= olst_pkg::ST_FULL;
              end else begin
                count <= CW'(count + 1'b1);
              end
              state <= S_DONE;
            end
            olst_pkg::OP_INSERT: begin
              if (pos_x > cnt_x) begin
                status <= olst_pkg::ST_RANGE;
                state  <= S_DONE;
              end else if (full) begin
                status <= olst_pkg::ST_FULL;
                state  <= S_DONE;
              end else begin
                ptr   <= AW'(count - 1'b1);
                rem   <= CW'(cnt_x - pos_x);
                state <= S_SHIFT;
              end
            end
            olst_pkg::OP_READ: begin
              if (pos_x >= cnt_x) begin
                status <= olst_pkg::ST_RANGE;
                state  <= S_DONE;
              end else begin
                state <= S_RDWAIT;
              end
            end
            olst_pkg::OP_FIND: begin
              ptr   <= '0;
              rem   <= count;
              state <= S_SCAN;
            end
          endcase
        end
        S_SHIFT: begin
          pend <= issue;
          if (issue) begin
            tag <= ptr;
            ptr <= AW'(ptr - 1'b1);
            rem <= CW'(rem - 1'b1);
          end
          if (!issue && !pend) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          count <= CW'(count + 1'b1);
          state <= S_DONE;
        end
        S_RDWAIT: begin
          rd_val <= rd_data;
          state  <= S_DONE;
        end
        S_SCAN: begin
          if (match) begin
            found <= tag;
            pend  <= 1'b0;
            state <= S_DONE;
          end else begin
            pend <= issue;
            if (issue) begin
              tag <= ptr;
              ptr <= AW'(ptr + 1'b1);
              rem <= CW'(rem - 1'b1);
            end
            if (!issue && !pend) begin
              status <= olst_pkg::ST_NOTFOUND;
              state  <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == CW'($past(count) + 1'b1)))
    else $error("entry count moved by other than one");

  a_shift_ports: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && pend && issue) |-> (wr_addr != rd_addr))
    else $error("shift reads and writes the same entry");

  a_found_below: assert property (@(posedge clk) disable iff (rst)
    (res_valid && op == olst_pkg::OP_FIND && status == olst_pkg::ST_OK)
      |-> (CW'(found) < count))
    else $error("find hit beyond the list end");
`endif

endmodule

// ===== hdl/ordered_list_store_top.sv =====
// ----------------------------------------------------------------------------
// ordered_list_store_top: ordered list of 32-bit words in a fixed store
// Append, insert-with-shift, read by position and find-first on a store of
// CAPACITY entries; every request returns status, count and empty flag.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (low bit up)                          tuser
//  s_axis    in   value[31:0] position[38:32] pad[39]         op[1:0]
//  m_axis    out  read_value[31:0] found_position[37:32]      status[1:0]
//                 count[44:38] empty_res[45] pad[47:46]
//
// Steps per request, accept to result in the output register:
//   append and any range or full error finish at decode; read waits for
//   the registered store data. insert shifts entries up from the end down
//   to the position, then writes the word; the store's single read port
//   moves one entry per cycle. find compares entries upward from the head,
//   one entry per cycle, and stops at the first hit.
// s_axis_tready is high only while the sequencer is idle; one request at a
// time. A finished result sits in the output register while the next
// request is taken; the sequencer holds its result only if that register
// is still occupied.
// Reset clears the count and control; the store itself is not cleared.
// ----------------------------------------------------------------------------
module ordered_list_store_top #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value[31:0], position[38:32], zero pad
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // read_value, found_position, count,
                                      // empty_res, zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [olst_pkg::VALUE_W-1:0] wr_data;
  logic [AW-1:0]                rd_addr;
  logic [olst_pkg::VALUE_W-1:0] rd_data;
  logic                         out_free;
  logic                         res_valid;
  olst_pkg::res_t               res;

  // output register frees when empty or being drained this cycle
  assign out_free = !m_axis_tvalid || m_axis_tready;

  olst_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  olst_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_op       (s_axis_tuser),
    .in_value    (s_axis_tdata[31:0]),
    .in_position (s_axis_tdata[38:32]),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  // result transfer register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_axis_tuser <= res.status;
      m_axis_tdata <= {2'b00, res.empty_res, res.count,
                       res.found_position, res.read_value};
    end
  end

endmodule

// ===== verif/ordered_list_store_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_store_top_tb: self-checking bench for the ordered list store
// Drives append, insert, read and find requests over the input stream and
// checks every result transfer against a cycle-free model of the list kept
// in the bench. Directed cases cover the empty list, shifting inserts,
// range errors, misses and the full store; a random part follows under
// several idle and stall mixes, plus one long output hold-off.
// ----------------------------------------------------------------------------
module ordered_list_store_top_tb;

  localparam int CAPACITY    = 64;
  localparam int HOLD_CYCLES = 300;   // long output hold-off for back-pressure
  localparam int STALL_LIMIT = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_WAIT  = 100;   // longer than the worst request latency
  localparam int PHASE_ITEMS = 300;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // value[31:0], position[38:32], zero pad
  logic [1:0]  s_axis_tuser;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // read_value, found_position, count, empty_res
  logic [1:0]  m_axis_tuser;   // status[1:0]

  // Bench copy of the list; only entries below list_len are ever looked at.
  logic [olst_pkg::VALUE_W-1:0] list_words [CAPACITY];
  int                           list_len;

  // Results owed by the block, oldest first.
  olst_pkg::res_t replies_due[$];

  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;   // bumped by the test sequence
  int holds_served;    // bumped by the receiver when it starts a hold-off
  int hold_left;
  int quiet_cycles;
  olst_pkg::res_t got_reply;
  olst_pkg::res_t want_reply;

  ordered_list_store_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // List model: applies one accepted request and returns the result it owes.
  // Words compare as raw bit patterns, so sign plays no part in a find.
  // --------------------------------------------------------------------------
  function automatic olst_pkg::res_t predict_request(
      input logic [1:0]                   op,
      input logic [olst_pkg::VALUE_W-1:0] word,
      input logic [olst_pkg::POS_W-1:0]   pos);
    olst_pkg::res_t r;
    int             k;
    r        = '0;
    r.status = olst_pkg::ST_OK;
    case (op)
      olst_pkg::OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = olst_pkg::ST_FULL;
        end else begin
          list_words[list_len] = word;
          list_len++;
        end
      end
      olst_pkg::OP_INSERT: begin
        // position test comes first, so a far insert on a full list is a range error
        if (int'(pos) > list_len) begin
          r.status = olst_pkg::ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          r.status = olst_pkg::ST_FULL;
        end else begin
          for (k = list_len; k > int'(pos); k--) list_words[k] = list_words[k-1];
          list_words[pos] = word;
          list_len++;
        end
      end
      olst_pkg::OP_READ: begin
        if (int'(pos) >= list_len) r.status = olst_pkg::ST_RANGE;
        else r.read_value = list_words[pos];
      end
      default: begin
        r.status = olst_pkg::ST_NOTFOUND;
        for (k = 0; k < list_len; k++) begin
          if (list_words[k] == word) begin
            r.status         = olst_pkg::ST_OK;
            r.found_position = k[olst_pkg::FOUND_W-1:0];
            break;
          end
        end
      end
    endcase
    r.count     = list_len[olst_pkg::COUNT_W-1:0];
    r.empty_res = (list_len == 0);
    return r;
  endfunction

  // Word mix: extremes, a few small values (for duplicates) and plain random.
  function automatic logic [olst_pkg::VALUE_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return 32'($signed($urandom_range(4)) - 2);
      default: return $urandom;
    endcase
  endfunction

  // Search key: usually something already stored so finds hit at many depths.
  function automatic logic [olst_pkg::VALUE_W-1:0] pick_key();
    if (list_len > 0 && $urandom_range(99) < 60)
      return list_words[$urandom_range(list_len - 1)];
    return pick_word();
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Starts at a falling edge, may idle, then holds the request
  // until the transfer edge. Returns right after that rising edge, so the
  // next call (or an explicit drop of tvalid) owns the following falling edge.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [1:0]                   op,
                              input logic [olst_pkg::VALUE_W-1:0] word,
                              input logic [olst_pkg::POS_W-1:0]   pos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, pos, word};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    replies_due.push_back(predict_request(op, word, pos));
  endtask

  // One random request, weighted toward reads and finds so the list grows
  // slowly and every fill level sees traffic before the store is full.
  task automatic send_random_request();
    int                             r;
    logic [1:0]                     op;
    logic [olst_pkg::POS_W-1:0]     pos;
    r   = $urandom_range(99);
    op  = (r < 7)  ? olst_pkg::OP_APPEND :
          (r < 14) ? olst_pkg::OP_INSERT :
          (r < 57) ? olst_pkg::OP_READ : olst_pkg::OP_FIND;
    pos = olst_pkg::POS_W'($urandom_range(127));
    if ((op == olst_pkg::OP_INSERT || op == olst_pkg::OP_READ) &&
        $urandom_range(99) < 80)
      pos = olst_pkg::POS_W'($urandom_range(list_len));
    send_request(op, (op == olst_pkg::OP_FIND) ? pick_key() : pick_word(), pos);
  endtask

  // --------------------------------------------------------------------------
  // Output side. Random stall per cycle, or a counted hold-off on request.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker and watchdog, both on the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_reply.status         = m_axis_tuser;
      got_reply.read_value     = m_axis_tdata[31:0];
      got_reply.found_position = m_axis_tdata[37:32];
      got_reply.count          = m_axis_tdata[44:38];
      got_reply.empty_res      = m_axis_tdata[45];
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d read_value %h found %0d count %0d empty %0d",
                 $time, got_reply.status, got_reply.read_value,
                 got_reply.found_position, got_reply.count, got_reply.empty_res);
      end else begin
        want_reply = replies_due.pop_front();
        if (got_reply !== want_reply) begin
          errors++;
          $display("%0t: mismatch expected status %0d read_value %h found %0d count %0d empty %0d",
                   $time, want_reply.status, want_reply.read_value,
                   want_reply.found_position, want_reply.count, want_reply.empty_res);
          $display("%0t:          actual status %0d read_value %h found %0d count %0d empty %0d",
                   $time, got_reply.status, got_reply.read_value,
                   got_reply.found_position, got_reply.count, got_reply.empty_res);
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Nothing stored yet: reads, find and a far insert all miss.
  task automatic test_empty_list();
    send_request(olst_pkg::OP_READ, 32'h0, 7'd0);
    send_request(olst_pkg::OP_READ, 32'h0, 7'd127);
    send_request(olst_pkg::OP_FIND, 32'h0, 7'd0);
    send_request(olst_pkg::OP_INSERT, 32'h1234_5678, 7'd1);
  endtask

  // Build a short list by inserts at the head, middle and tail.
  task automatic test_insert_shift();
    send_request(olst_pkg::OP_INSERT, 32'h7fff_ffff, 7'd0);
    send_request(olst_pkg::OP_APPEND, 32'h8000_0000, 7'd127);
    send_request(olst_pkg::OP_INSERT, 32'hffff_ffff, 7'd2);  // at the count: acts as append
    send_request(olst_pkg::OP_INSERT, 32'h0000_0000, 7'd1);
    send_request(olst_pkg::OP_INSERT, 32'h0000_0001, 7'd0);
    send_request(olst_pkg::OP_INSERT, 32'h5555_aaaa, 7'd6);  // one past the count
  endtask

  // Read every entry and one past the end, then hit, miss and duplicate finds.
  task automatic test_read_find();
    int i;
    for (i = 0; i <= 5; i++) send_request(olst_pkg::OP_READ, 32'h0, 7'(i));
    send_request(olst_pkg::OP_FIND, 32'hffff_ffff, 7'd0);
    send_request(olst_pkg::OP_FIND, 32'h0000_0000, 7'd0);
    send_request(olst_pkg::OP_FIND, 32'h1234_5678, 7'd0);
    send_request(olst_pkg::OP_APPEND, 32'hffff_ffff, 7'd0);
    send_request(olst_pkg::OP_FIND, 32'hffff_ffff, 7'd0);  // must return the earlier copy
  endtask

  task automatic test_random_traffic(input int items, input int idle_pct,
                                     input int stall_pct);
    int i;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < items; i++) send_random_request();
  endtask

  // Output held off for a long stretch while requests keep coming, so the
  // output register and the sequencer both fill and input tready drops.
  task automatic test_backpressure();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    for (i = 0; i < 10; i++) send_random_request();
  endtask

  // Top the list up to capacity, then every full and range case.
  task automatic test_full_store();
    while (list_len < CAPACITY) send_request(olst_pkg::OP_APPEND, pick_word(), 7'd0);
    send_request(olst_pkg::OP_APPEND, 32'h0bad_0bad, 7'd0);
    send_request(olst_pkg::OP_INSERT, 32'h0bad_0bad, 7'd64);   // at the count but full
    send_request(olst_pkg::OP_INSERT, 32'h0bad_0bad, 7'd0);
    send_request(olst_pkg::OP_INSERT, 32'h0bad_0bad, 7'd65);   // range wins over full
    send_request(olst_pkg::OP_INSERT, 32'h0bad_0bad, 7'd127);
    send_request(olst_pkg::OP_READ, 32'h0, 7'd63);
    send_request(olst_pkg::OP_READ, 32'h0, 7'd64);
    send_request(olst_pkg::OP_FIND, list_words[CAPACITY-1], 7'd0);
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = olst_pkg::OP_APPEND;
    m_axis_tready  = 1'b0;
    list_len       = 0;
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    holds_served   = 0;
    hold_left      = 0;
    quiet_cycles   = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_insert_shift();
    test_read_find();
    test_random_traffic(PHASE_ITEMS, 0, 0);
    test_random_traffic(PHASE_ITEMS, 46, 0);
    test_backpressure();
    test_random_traffic(PHASE_ITEMS, 0, 46);
    test_random_traffic(PHASE_ITEMS, 21, 21);
    test_full_store();

    // Stop offering, collect the outstanding results, then give the block
    // time to show any stray transfer.
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && replies_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
